### hdl/lfps_pkg.sv
// Shared types and constants of the line-follow steering controller.
`timescale 1ns / 1ps
package lfps_pkg;

  // Sensor array and field widths
  localparam int unsigned SENSOR_CNT = 9;
  localparam int unsigned COLOR_W    = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ERR_W      = 5;
  localparam int unsigned SERVO_W    = 7;
  localparam int unsigned ERR_MAX    = 8;

  // Hit count and index sum widths
  localparam int unsigned CNT_W = $clog2(SENSOR_CNT + 1);
  localparam int unsigned SUM_W = $clog2((SENSOR_CNT * (SENSOR_CNT - 1)) / 2 + 1);

  // Error history ring
  localparam int unsigned HIST_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(HIST_DEPTH);
  localparam int unsigned HS_W       = $clog2((HIST_DEPTH - 1) * ERR_MAX + 1) + 1;

  // Near window around the newest error
  localparam int unsigned NEAR_WIN = 4;

  // Rounding divider: quotient never exceeds ERR_MAX
  localparam int unsigned DIV_BITS = $clog2(ERR_MAX + 1);
  localparam int unsigned DBIT_W   = $clog2(DIV_BITS);
  localparam int unsigned DVD_W    = 8;
  localparam int unsigned DVS_W    = CNT_W + 1;

  // Control law, gains scaled by 100
  localparam int unsigned GAIN_PD     = 700;
  localparam int unsigned GAIN_I      = 2;
  localparam int unsigned DRIVE_LIMIT = 48;
  localparam int unsigned NUM_MAX     = GAIN_PD * 3 * ERR_MAX
                                      + GAIN_I * (HIST_DEPTH - 1) * ERR_MAX;
  localparam int unsigned NUM_W       = $clog2(NUM_MAX + 1) + 1;
  localparam int unsigned MAG_W       = NUM_W - 1;
  localparam int unsigned ED_W        = 6;

  // Scale by 1/100 as multiply by RECIP_K and shift by RECIP_SH; exact below SAT_MAG
  localparam int unsigned SAT_MAG  = (DRIVE_LIMIT + 1) * 100;
  localparam int unsigned SCL_W    = $clog2(SAT_MAG);
  localparam int unsigned RECIP_K  = 5243;
  localparam int unsigned RECIP_SH = 19;
  localparam int unsigned RPROD_W  = SCL_W + 13;
  localparam int unsigned DRV_W    = $clog2(DRIVE_LIMIT + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = COLOR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_MODE  = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_P   = 2'd0,
    MODE_PI  = 2'd1,
    MODE_PD  = 2'd2,
    MODE_PID = 2'd3
  } mode_e;

  // Controller to datapath commands
  typedef struct packed {
    logic              start;
    logic              div_step;
    logic [DBIT_W-1:0] div_bit;
    logic              update;
    logic              calc;
    logic              scale;
    logic              load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### hdl/lfps_if.sv
// Handshake channels for sensor items and result items.
`timescale 1ns / 1ps
interface lfps_in_if;
  import lfps_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] sensor_color_0;
  logic [COLOR_W-1:0] sensor_color_1;
  logic [COLOR_W-1:0] sensor_color_2;
  logic [COLOR_W-1:0] sensor_color_3;
  logic [COLOR_W-1:0] sensor_color_4;
  logic [COLOR_W-1:0] sensor_color_5;
  logic [COLOR_W-1:0] sensor_color_6;
  logic [COLOR_W-1:0] sensor_color_7;
  logic [COLOR_W-1:0] sensor_color_8;

  modport source (
    output valid, sensor_color_0, sensor_color_1, sensor_color_2, sensor_color_3,
           sensor_color_4, sensor_color_5, sensor_color_6, sensor_color_7,
           sensor_color_8,
    input  ready
  );

  modport sink (
    input  valid, sensor_color_0, sensor_color_1, sensor_color_2, sensor_color_3,
           sensor_color_4, sensor_color_5, sensor_color_6, sensor_color_7,
           sensor_color_8,
    output ready
  );
endinterface

interface lfps_out_if;
  import lfps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SERVO_W-1:0] servo_position;
  logic signed [ERR_W-1:0]   steering_error;
  logic                      line_found;

  modport source (
    output valid, servo_position, steering_error, line_found,
    input  ready
  );

  modport sink (
    input  valid, servo_position, steering_error, line_found,
    output ready
  );
endinterface

### hdl/lfps_ctrl.sv
// Sequencer of the steering controller: steps one item through the datapath.
`timescale 1ns / 1ps
module lfps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lfps_pkg::sts_t sts_i,
  output lfps_pkg::cmd_t cmd_o
);
  import lfps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_MUL,
    S_SCL,
    S_OUT
  } state_e;

  state_e            state_q;
  logic              in_ready_q;
  logic [DBIT_W-1:0] bit_q;

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
      bit_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_DIV;
            in_ready_q <= 1'b0;
            bit_q      <= DBIT_W'(DIV_BITS - 1);
          end
        end
        S_DIV: begin
          if (bit_q == '0) begin
            state_q <= S_UPD;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_UPD: state_q <= S_MUL;
        S_MUL: state_q <= S_SCL;
        S_SCL: state_q <= S_OUT;
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = in_valid_i && in_ready_q;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.div_bit  = bit_q;
    cmd_o.update   = (state_q == S_UPD);
    cmd_o.calc     = (state_q == S_MUL);
    cmd_o.scale    = (state_q == S_SCL);
    cmd_o.load_out = (state_q == S_OUT) && sts_i.out_free;
  end

  a_start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == S_DIV)
    else $error("accepted item did not start the divider");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == S_IDLE)
    else $error("ready raised outside idle");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !sts_i.out_free) |=> state_q == S_OUT)
    else $error("result dropped while output register busy");

endmodule

### hdl/lfps_dp.sv
// Datapath: hit test, rounding divider, error ring, PID law and output register.
`timescale 1ns / 1ps
module lfps_dp (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]                         cfg_idx_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]                        cfg_data_i,
  input  logic [lfps_pkg::SENSOR_CNT-1:0][lfps_pkg::COLOR_W-1:0] color_i,
  input  lfps_pkg::cmd_t                                         cmd_i,
  output lfps_pkg::sts_t                                         sts_o,
  output logic                                                   out_valid_o,
  input  logic                                                   out_ready_i,
  output logic signed [lfps_pkg::SERVO_W-1:0]                    servo_o,
  output logic signed [lfps_pkg::ERR_W-1:0]                      err_o,
  output logic                                                   found_o
);
  import lfps_pkg::*;

  // Configuration registers
  logic [COLOR_W-1:0] line_color_q;
  mode_e              mode_q;

  // Ring state
  logic signed [ERR_W-1:0] hist_q [HIST_DEPTH];
  logic [PTR_W-1:0]        wp_q, op_q;
  logic                    seen_q;
  logic signed [ERR_W-1:0] last_q, prev_q;
  logic signed [HS_W-1:0]  hs_q;
  logic signed [ERR_W-1:0] rd_q;

  // Per-item working registers
  logic [DVD_W-1:0]        rem_q;
  logic [DVS_W-1:0]        dvs_q;
  logic [DIV_BITS-1:0]     quo_q;
  logic                    neg_q;
  logic                    found_q;
  logic signed [ERR_W-1:0] err_q;
  logic [MAG_W-1:0]        mag_q;
  logic                    dneg_q;
  logic [DRV_W-1:0]        drv_q;

  // Output register
  logic                      out_valid_q;
  logic signed [SERVO_W-1:0] servo_q;
  logic signed [ERR_W-1:0]   oerr_q;
  logic                      ofound_q;

  // Combinational nets
  logic                    check_near;
  logic signed [6:0]       last_w;
  logic [SENSOR_CNT-1:0]   hit;
  logic [CNT_W-1:0]        hit_cnt;
  logic [SUM_W-1:0]        idx_sum;
  logic signed [7:0]       n_w;
  logic [6:0]              n_mag;
  logic [DVD_W-1:0]        dvd_w;
  logic [DVD_W:0]          trial_w;
  logic signed [ERR_W-1:0] err_w;
  logic [PTR_W-1:0]        wp_nx, op_nx;
  logic                    drop_w;
  logic signed [ED_W-1:0]  ed_w;
  logic signed [NUM_W-1:0] numer_w;
  logic [RPROD_W-1:0]      rprod_w;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_color_q <= '0;
      mode_q       <= MODE_PID;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LINE_COLOR) begin
        line_color_q <= cfg_data_i[COLOR_W-1:0];
      end else if (cfg_idx_i == CFG_CTRL_MODE) begin
        mode_q <= mode_e'(cfg_data_i[MODE_W-1:0]);
      end
    end
  end

  // Hit test against the newest error
  assign check_near = (wp_q != op_q) && seen_q;
  assign last_w     = 7'(last_q);

  always_comb begin
    for (int i = 0; i < SENSOR_CNT; i++) begin
      hit[i] = (color_i[i] == line_color_q) &&
               (!check_near ||
                ((7'(2 * i - 8) < last_w + $signed(7'(NEAR_WIN))) &&
                 (7'(2 * i - 8) > last_w - $signed(7'(NEAR_WIN)))));
    end
  end

  // Hit count and index sum
  always_comb begin
    hit_cnt = '0;
    idx_sum = '0;
    for (int i = 0; i < SENSOR_CNT; i++) begin
      if (hit[i]) begin
        hit_cnt = hit_cnt + 1'b1;
        idx_sum = idx_sum + SUM_W'(i);
      end
    end
  end

  // Rounded mean: (2|n| + H) / (2H)
  assign n_w   = $signed({1'b0, idx_sum, 1'b0}) - $signed({1'b0, hit_cnt, 3'b000});
  assign n_mag = 7'(n_w[7] ? -n_w : n_w);
  assign dvd_w = {n_mag, 1'b0} + DVD_W'(hit_cnt);

  // Restoring divider, one quotient bit per step
  assign trial_w = (DVD_W + 1)'(dvs_q) << cmd_i.div_bit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q   <= dvd_w;
      dvs_q   <= {hit_cnt, 1'b0};
      quo_q   <= '0;
      neg_q   <= n_w[7];
      found_q <= |hit;
    end else if (cmd_i.div_step) begin
      if ((DVD_W + 1)'(rem_q) >= trial_w) begin
        rem_q                <= rem_q - trial_w[DVD_W-1:0];
        quo_q[cmd_i.div_bit] <= 1'b1;
      end
    end
  end

  // Error of this item
  always_comb begin
    if (found_q) begin
      err_w = neg_q ? -ERR_W'(quo_q) : ERR_W'(quo_q);
    end else if (wp_q == op_q) begin
      err_w = '0;
    end else begin
      err_w = last_q;
    end
  end

  assign wp_nx  = (wp_q == PTR_W'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign op_nx  = (op_q == PTR_W'(HIST_DEPTH - 1)) ? '0 : op_q + 1'b1;
  assign drop_w = (wp_nx == op_q);

  // History memory: push at update, oldest entry read at start
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && found_q) begin
      hist_q[wp_q] <= err_w;
    end
    if (cmd_i.start) begin
      rd_q <= hist_q[op_q];
    end
  end

  // Ring pointers, running sum and newest two entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      op_q   <= '0;
      seen_q <= 1'b0;
      last_q <= '0;
      prev_q <= '0;
      hs_q   <= '0;
    end else if (cmd_i.update) begin
      seen_q <= found_q;
      if (found_q) begin
        wp_q   <= wp_nx;
        last_q <= err_w;
        prev_q <= last_q;
        if (drop_w) begin
          op_q <= op_nx;
          hs_q <= hs_q + HS_W'(err_w) - HS_W'(rd_q);
        end else begin
          hs_q <= hs_q + HS_W'(err_w);
        end
      end
    end
  end

  // PID numerator
  always_comb begin
    ed_w = ED_W'(err_q);
    if (mode_q == MODE_PD || mode_q == MODE_PID) begin
      ed_w = ed_w + ED_W'(last_q) - ED_W'(prev_q);
    end
    numer_w = NUM_W'(ed_w) * $signed(NUM_W'(GAIN_PD));
    if (mode_q == MODE_PI || mode_q == MODE_PID) begin
      numer_w = numer_w + NUM_W'(hs_q) * $signed(NUM_W'(GAIN_I));
    end
  end

  // Scale by 1/100 through a reciprocal
  assign rprod_w = RPROD_W'(mag_q[SCL_W-1:0]) * RPROD_W'(RECIP_K);

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      err_q <= err_w;
    end
    if (cmd_i.calc) begin
      dneg_q <= numer_w[NUM_W-1];
      mag_q  <= MAG_W'(numer_w[NUM_W-1] ? -numer_w : numer_w);
    end
    if (cmd_i.scale) begin
      if (mag_q >= MAG_W'(SAT_MAG)) begin
        drv_q <= DRV_W'(DRIVE_LIMIT);
      end else begin
        drv_q <= rprod_w[RECIP_SH +: DRV_W];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      servo_q  <= dneg_q ? -SERVO_W'(drv_q) : SERVO_W'(drv_q);
      oerr_q   <= err_q;
      ofound_q <= found_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign servo_o        = servo_q;
  assign err_o          = oerr_q;
  assign found_o        = ofound_q;

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && found_q) |=> wp_q != op_q)
    else $error("ring empty after a push");

  a_nohit_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && !found_q) |=> $stable(wp_q) && $stable(hs_q))
    else $error("ring changed on an item without hits");

  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (servo_q <= $signed(SERVO_W'(DRIVE_LIMIT))) &&
                    (servo_q >= -$signed(SERVO_W'(DRIVE_LIMIT))))
    else $error("servo value beyond saturation limit");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (oerr_q <= $signed(ERR_W'(ERR_MAX))) &&
                    (oerr_q >= -$signed(ERR_W'(ERR_MAX))))
    else $error("steering error out of range");

endmodule

### hdl/line_follow_pid_steering.sv
// Top level of the line-follow PID steering controller.
`timescale 1ns / 1ps
// Takes one item of nine sensor colour codes and returns one result item with
// the saturated servo value, the steering error and a line-found flag. Items are
// accepted only in the idle state; each accepted item then passes through the
// rounding divider for the mean sensor position (one quotient bit per step),
// error update, PID multiply, scaling by 1/100 and the output load before the
// next is taken. The output load waits while the previous result is still held,
// so a stalled receiver stalls the input. The result sits in an output register,
// so the next item is accepted while it waits. Configuration (line colour at
// index 0, controller mode at index 1) must be written through cfg_we_i only
// while no item is in flight; the block itself does not enforce this.
module line_follow_pid_steering (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lfps_in_if.sink                         in_i,
  lfps_out_if.source                      out_o
);
  import lfps_pkg::*;

  cmd_t                               cmd;
  sts_t                               sts;
  logic                               in_ready;
  logic [SENSOR_CNT-1:0][COLOR_W-1:0] color;

  // Gather sensor fields
  assign color[0] = in_i.sensor_color_0;
  assign color[1] = in_i.sensor_color_1;
  assign color[2] = in_i.sensor_color_2;
  assign color[3] = in_i.sensor_color_3;
  assign color[4] = in_i.sensor_color_4;
  assign color[5] = in_i.sensor_color_5;
  assign color[6] = in_i.sensor_color_6;
  assign color[7] = in_i.sensor_color_7;
  assign color[8] = in_i.sensor_color_8;

  assign in_i.ready = in_ready;

  lfps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .color_i     (color),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .servo_o     (out_o.servo_position),
    .err_o       (out_o.steering_error),
    .found_o     (out_o.line_found)
  );

endmodule
